@@ hdl/ftbrc_pkg.sv @@
// Shared types, constants and fixed-point helpers of the ray compositor.
`default_nettype none

package ftbrc_pkg;

	// Default fraction bits of the Q1.F accumulators
	localparam int FRAC_BITS_DEF = 16;
	// Default depth of the queue between front and back
	localparam int QUEUE_DEPTH_DEF = 4;

	// Cutoff register: Q1.16 with one integer bit
	localparam int CFG_W = 17;
	localparam logic [CFG_W-1:0] CUTOFF_RESET = 17'd64225;

	// Largest byte value, the scale of colors and opacities
	localparam logic [7:0] BYTE_MAX = 8'd255;

	// Width of the divide-by-255 helper; exact for inputs below 2^33
	localparam int DIV_W = 40;

	typedef struct packed {
		logic [7:0] sample_red;
		logic [7:0] sample_green;
		logic [7:0] sample_blue;
		logic [7:0] sample_opacity;
		logic       step_start;
		logic       last_sample;
		logic [7:0] bg_red;
		logic [7:0] bg_green;
		logic [7:0] bg_blue;
	} sample_t;

	typedef struct packed {
		logic [7:0] pixel_red;
		logic [7:0] pixel_green;
		logic [7:0] pixel_blue;
		logic [7:0] comp_opacity;
	} pixel_t;

	// Queue entry: sample plus the front's classification
	typedef struct packed {
		sample_t smp;
		logic    empty;
	} qent_t;

	// floor(x / 255) by reciprocal series x/256 * (1 + 1/256 + ...),
	// which never overshoots and is at most one low, then one correction
	function automatic logic [DIV_W-1:0] div255(input logic [DIV_W-1:0] x);
		logic [DIV_W-1:0] s;
		logic [DIV_W-1:0] est;
		logic [DIV_W-1:0] r;
		s   = x + (x >> 8) + (x >> 16) + (x >> 24);
		est = s >> 8;
		r   = x - ((est << 8) - est);
		if (r >= DIV_W'(BYTE_MAX)) begin
			est = est + DIV_W'(1);
		end
		return est;
	endfunction

endpackage

`default_nettype wire

@@ hdl/front_to_back_ray_compositor.sv @@
// Top level of the front-to-back ray compositor.
//
// Usage: samples of one pixel enter through a queue-like port (push/full),
// in ray order; the item marked last_sample closes the pixel. Each pixel
// gives one result on a queue-like output (empty/pop): the composite blended
// over the background carried with the last sample, and its opacity.
// The user is to write the cutoff register on cfg_valid/cfg_ready only
// while idle; the block itself does not enforce it. A composited sample
// goes through weight multiply, divide by 255, colour multiplies and
// accumulate; an empty or ignored sample skips these. The last sample
// then goes through to bytes, blend multiply and divide. A front register
// and a short queue let input be accepted while the back end works or a
// result waits. When the receiver stalls, the result holds; the back end
// waits on its next result and the queue then fills until full rises.
// Reset clears accumulators, queue and the result's valid flag and loads the
// cutoff with about 0.98.
`default_nettype none

module front_to_back_ray_compositor #(
	parameter int FRAC_BITS   = ftbrc_pkg::FRAC_BITS_DEF,
	parameter int QUEUE_DEPTH = ftbrc_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        push,
	output logic                             full,
	input  wire ftbrc_pkg::sample_t          sample,
	output logic                             empty,
	input  wire logic                        pop,
	output ftbrc_pkg::pixel_t                pixel,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [ftbrc_pkg::CFG_W-1:0] cfg_data
);

	logic             q_full;
	logic             q_wr;
	ftbrc_pkg::qent_t q_wdata;
	logic             q_rd;
	logic             q_valid;
	ftbrc_pkg::qent_t q_rdata;
	logic             out_valid;

	assign cfg_ready = 1'b1;
	assign empty     = !out_valid;

	ftbrc_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.sample  (sample),
		.q_full  (q_full),
		.q_wr    (q_wr),
		.q_wdata (q_wdata)
	);

	ftbrc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.wdata  (q_wdata),
		.full   (q_full),
		.rd     (q_rd),
		.rdata  (q_rdata),
		.valid  (q_valid)
	);

	ftbrc_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr    (cfg_valid),
		.cfg_data  (cfg_data),
		.q_valid   (q_valid),
		.q_rdata   (q_rdata),
		.q_rd      (q_rd),
		.out_valid (out_valid),
		.out_pixel (pixel),
		.out_pop   (pop && out_valid)
	);

endmodule

`default_nettype wire

@@ hdl/ftbrc_front.sv @@
// Front stage: accepts samples, classifies empty ones, feeds the queue.
`default_nettype none

module ftbrc_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire ftbrc_pkg::sample_t sample,
	input  wire logic               q_full,
	output logic                    q_wr,
	output ftbrc_pkg::qent_t        q_wdata
);

	logic             vld_s1;
	ftbrc_pkg::qent_t ent_s1;
	logic             take;

	// Stall only when the stage holds an item the queue cannot take
	assign full    = vld_s1 && q_full;
	assign take    = push && !full;
	assign q_wr    = vld_s1 && !q_full;
	assign q_wdata = ent_s1;

	// Track stage occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (take) begin
			vld_s1 <= 1'b1;
		end else if (q_wr) begin
			vld_s1 <= 1'b0;
		end
	end

	// Capture and classify the item
	always_ff @(posedge clk) begin
		if (take) begin
			ent_s1.smp   <= sample;
			ent_s1.empty <= (sample.sample_opacity == 8'd0);
		end
	end

endmodule

`default_nettype wire

@@ hdl/ftbrc_queue.sv @@
// Short queue that decouples the front stage from the compositing back end.
`default_nettype none

module ftbrc_queue #(
	parameter int DEPTH = ftbrc_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr,
	input  wire ftbrc_pkg::qent_t wdata,
	output logic                  full,
	input  wire logic             rd,
	output ftbrc_pkg::qent_t      rdata,
	output logic                  valid
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	ftbrc_pkg::qent_t mem [DEPTH];
	logic [PW-1:0]    wp_q;
	logic [PW-1:0]    rp_q;
	logic [CW-1:0]    cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full  = (cnt_q == CW'(DEPTH));
	assign valid = (cnt_q != CW'(0));
	assign do_wr = wr && !full;
	assign do_rd = rd && valid;
	assign rdata = mem[rp_q];

	// Store the incoming item
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem[wp_q] <= wdata;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + PW'(1);
			end
			if (do_rd) begin
				rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + PW'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

@@ hdl/ftbrc_back.sv @@
// Back end: front-to-back accumulation, final blend and result register.
`default_nettype none

module ftbrc_back #(
	parameter int FRAC_BITS = ftbrc_pkg::FRAC_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_wr,
	input  wire logic [ftbrc_pkg::CFG_W-1:0]    cfg_data,
	input  wire logic                           q_valid,
	input  wire ftbrc_pkg::qent_t               q_rdata,
	output logic                                q_rd,
	output logic                                out_valid,
	output ftbrc_pkg::pixel_t                   out_pixel,
	input  wire logic                           out_pop
);

	localparam int AW  = FRAC_BITS + 1;
	localparam int PW  = AW + 8;
	localparam int CUP = (FRAC_BITS >= 16) ? (FRAC_BITS - 16) : 0;
	localparam int CDN = (FRAC_BITS >= 16) ? 0 : (16 - FRAC_BITS);
	localparam int CW  = ftbrc_pkg::CFG_W + CUP;
	localparam int MW  = (CW > AW) ? CW : AW;
	localparam logic [AW-1:0] ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_WGT  = 7'b0000010,
		ST_COL  = 7'b0000100,
		ST_ACC  = 7'b0001000,
		ST_FIN  = 7'b0010000,
		ST_MIX  = 7'b0100000,
		ST_OUT  = 7'b1000000
	} state_t;

	state_t                      state_q;
	logic [ftbrc_pkg::CFG_W-1:0] cutoff_q;
	logic [AW-1:0]               acc_a_q;
	logic [AW-1:0]               acc_r_q;
	logic [AW-1:0]               acc_g_q;
	logic [AW-1:0]               acc_b_q;
	logic                        halted_q;
	ftbrc_pkg::qent_t            item_q;
	logic [PW-1:0]               prod_q;
	logic [AW-1:0]               w_q;
	logic [PW-1:0]               pr_q;
	logic [PW-1:0]               pg_q;
	logic [PW-1:0]               pb_q;
	logic [7:0]                  ca_q;
	logic [7:0]                  cr_q;
	logic [7:0]                  cg_q;
	logic [7:0]                  cb_q;
	logic [15:0]                 nr_q;
	logic [15:0]                 ng_q;
	logic [15:0]                 nb_q;
	logic                        out_valid_q;
	ftbrc_pkg::pixel_t           pixel_q;

	logic [CW-1:0]               cut;
	logic                        halt_now;
	logic [AW-1:0]               rem;
	logic                        out_free;
	logic [7:0]                  inv_a;

	// Q1.F value to a byte: min(255, floor(q * 255 / ONE))
	function automatic logic [7:0] to_byte(input logic [AW-1:0] q);
		logic [PW-1:0] t;
		logic [8:0]    v;
		t = (PW'(q) << 8) - PW'(q);
		v = t[FRAC_BITS+8:FRAC_BITS];
		return v[8] ? ftbrc_pkg::BYTE_MAX : v[7:0];
	endfunction

	// Colour term of one accumulator: floor(p / 255)
	function automatic logic [AW-1:0] col_term(input logic [PW-1:0] p);
		logic [ftbrc_pkg::DIV_W-1:0] d;
		d = ftbrc_pkg::div255(ftbrc_pkg::DIV_W'(p));
		return d[AW-1:0];
	endfunction

	// Final blend of one channel: floor(n / 255)
	function automatic logic [7:0] mix_out(input logic [15:0] n);
		logic [ftbrc_pkg::DIV_W-1:0] d;
		d = ftbrc_pkg::div255(ftbrc_pkg::DIV_W'(n));
		return d[7:0];
	endfunction

	// Rescale the cutoff to Q1.F and test the halt condition
	always_comb begin
		cut      = (CW'(cutoff_q) << CUP) >> CDN;
		halt_now = halted_q ||
			(q_rdata.smp.step_start && (MW'(acc_a_q) >= MW'(cut)));
		rem      = ONE_Q - acc_a_q;
		inv_a    = ftbrc_pkg::BYTE_MAX - ca_q;
	end

	assign q_rd      = (state_q == ST_IDLE);
	assign out_free  = !out_valid_q || out_pop;
	assign out_valid = out_valid_q;
	assign out_pixel = pixel_q;

	// Hold the cutoff register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cutoff_q <= ftbrc_pkg::CUTOFF_RESET;
		end else if (cfg_wr) begin
			cutoff_q <= cfg_data;
		end
	end

	// Sequence one item and update the per-pixel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			acc_a_q     <= '0;
			acc_r_q     <= '0;
			acc_g_q     <= '0;
			acc_b_q     <= '0;
			halted_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// Raise the result on a new pixel, drop it when taken
			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_pop) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						halted_q <= halt_now;
						if (!halt_now && !q_rdata.empty) begin
							state_q <= ST_WGT;
						end else if (q_rdata.smp.last_sample) begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_WGT: state_q <= ST_COL;
				ST_COL: state_q <= ST_ACC;
				ST_ACC: begin
					acc_r_q <= acc_r_q + col_term(pr_q);
					acc_g_q <= acc_g_q + col_term(pg_q);
					acc_b_q <= acc_b_q + col_term(pb_q);
					acc_a_q <= acc_a_q + w_q;
					state_q <= item_q.smp.last_sample ? ST_FIN : ST_IDLE;
				end
				ST_FIN: state_q <= ST_MIX;
				ST_MIX: state_q <= ST_OUT;
				ST_OUT: begin
					if (out_free) begin
						acc_a_q     <= '0;
						acc_r_q     <= '0;
						acc_g_q     <= '0;
						acc_b_q     <= '0;
						halted_q    <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers: item, weight, colour products, bytes, blend sums, result
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && q_valid) begin
			item_q <= q_rdata;
			prod_q <= PW'(rem) * PW'(q_rdata.smp.sample_opacity);
		end
		if (state_q == ST_WGT) begin
			w_q <= col_term(prod_q);
		end
		if (state_q == ST_COL) begin
			pr_q <= PW'(w_q) * PW'(item_q.smp.sample_red);
			pg_q <= PW'(w_q) * PW'(item_q.smp.sample_green);
			pb_q <= PW'(w_q) * PW'(item_q.smp.sample_blue);
		end
		if (state_q == ST_FIN) begin
			ca_q <= to_byte(acc_a_q);
			cr_q <= to_byte(acc_r_q);
			cg_q <= to_byte(acc_g_q);
			cb_q <= to_byte(acc_b_q);
		end
		if (state_q == ST_MIX) begin
			nr_q <= 16'(cr_q) * 16'(ca_q) + 16'(item_q.smp.bg_red) * 16'(inv_a);
			ng_q <= 16'(cg_q) * 16'(ca_q) + 16'(item_q.smp.bg_green) * 16'(inv_a);
			nb_q <= 16'(cb_q) * 16'(ca_q) + 16'(item_q.smp.bg_blue) * 16'(inv_a);
		end
		if (state_q == ST_OUT && out_free) begin
			pixel_q.pixel_red    <= mix_out(nr_q);
			pixel_q.pixel_green  <= mix_out(ng_q);
			pixel_q.pixel_blue   <= mix_out(nb_q);
			pixel_q.comp_opacity <= ca_q;
		end
	end

endmodule

`default_nettype wire

@@ hdl/ftbrc_checker.sv @@
// Port-level checker of the ray compositor and its bind statement.
`default_nettype none

module ftbrc_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              full,
	input wire logic              empty,
	input wire logic              pop,
	input wire ftbrc_pkg::pixel_t pixel,
	input wire logic              cfg_ready
);

	// Keep a waiting result until it is taken
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty)
		else $error("result dropped before pop");

	// Keep the waiting result's value unchanged
	a_stable_result: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> $stable(pixel))
		else $error("waiting result changed");

	// Show an empty, non-full block once reset has been applied for an edge
	a_reset_state: assert property (@(posedge clk)
		!arst_n && $past(!arst_n) |-> empty && !full)
		else $error("bad port state in reset");

	// Take configuration writes at any time
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port not ready");

endmodule

bind front_to_back_ray_compositor ftbrc_checker u_ftbrc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.full      (full),
	.empty     (empty),
	.pop       (pop),
	.pixel     (pixel),
	.cfg_ready (cfg_ready)
);

`default_nettype wire
